// File: rtl/adfp_pkg.sv
// Shared constants, types and decode function for the ASCII decimal frame parser.
package adfp_pkg;

  localparam int unsigned MaxPayloadDefault = 20;
  localparam int unsigned CountWidth        = 5;
  localparam int unsigned StoreDepth        = 12;

  localparam logic [7:0] ChOpen  = 8'h24;
  localparam logic [7:0] ChClose = 8'h23;
  localparam logic [7:0] ChZero  = 8'h30;

  localparam logic [15:0] ResetX = 16'd160;
  localparam logic [15:0] ResetY = 16'd120;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic        follow;
  } frame_t;

  // Three ASCII digits weighted 100, 10 and 1, each taken as byte minus '0', wrapped to 16 bits.
  function automatic logic [15:0] decode3(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    logic [15:0] d0;
    logic [15:0] d1;
    logic [15:0] d2;
    d0 = {8'd0, b0} - {8'd0, ChZero};
    d1 = {8'd0, b1} - {8'd0, ChZero};
    d2 = {8'd0, b2} - {8'd0, ChZero};
    return 16'((d0 * 16'd100) + (d1 * 16'd10) + d2);
  endfunction

endpackage

// File: rtl/adfp_parser.sv
// Frame tracking, payload store, decode of coordinates and the decoded-frame register.
module adfp_parser #(
  parameter int unsigned MaxPayload = adfp_pkg::MaxPayloadDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      rx_byte_i,
  input  logic            res_ready_i,
  output logic            frame_valid_o,
  output adfp_pkg::frame_t frame_o
);

  localparam int unsigned Cw = adfp_pkg::CountWidth;
  localparam int unsigned Sd = adfp_pkg::StoreDepth;

  logic                  follow_q;
  logic                  in_frame_q, in_frame_d;
  logic [Cw-1:0]         count_q, count_d;
  logic [Sd-1:0][7:0]    store_q, store_d;
  logic                  mid_valid_q, mid_valid_d;
  adfp_pkg::frame_t      mid_q, mid_d;

  logic                  mid_ready;
  logic                  accept;
  logic                  close_fire;
  logic [Cw-1:0]         count_inc;

  assign mid_ready  = !mid_valid_q || res_ready_i;
  assign in_stall_o = !mid_ready;
  assign accept     = in_valid_i && mid_ready;
  assign close_fire = accept && in_frame_q && (rx_byte_i == adfp_pkg::ChClose);
  assign count_inc  = count_q + Cw'(1);

  always_comb begin
    in_frame_d = in_frame_q;
    count_d    = count_q;
    store_d    = store_q;
    if (accept) begin
      if (!in_frame_q) begin
        if (rx_byte_i == adfp_pkg::ChOpen) begin
          in_frame_d = 1'b1;
          store_d    = '0;
        end
      end else if (rx_byte_i == adfp_pkg::ChClose) begin
        in_frame_d = 1'b0;
        count_d    = '0;
        store_d    = '0;
      end else if (rx_byte_i != adfp_pkg::ChOpen) begin
        for (int i = 0; i < Sd; i++) begin
          if (count_q == Cw'(i)) begin
            store_d[i] = rx_byte_i;
          end
        end
        count_d = count_inc;
        if (count_inc > Cw'(MaxPayload)) begin
          in_frame_d = 1'b0;
          count_d    = '0;
          store_d    = '0;
        end
      end
    end
  end

  always_comb begin
    mid_valid_d = mid_ready ? close_fire : mid_valid_q;
    mid_d       = mid_q;
    if (close_fire) begin
      mid_d.x      = adfp_pkg::decode3(store_q[0], store_q[1], store_q[2]);
      mid_d.y      = adfp_pkg::decode3(store_q[3], store_q[4], store_q[5]);
      mid_d.w      = adfp_pkg::decode3(store_q[6], store_q[7], store_q[8]);
      mid_d.h      = adfp_pkg::decode3(store_q[9], store_q[10], store_q[11]);
      mid_d.follow = follow_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      follow_q    <= 1'b0;
      in_frame_q  <= 1'b0;
      count_q     <= '0;
      store_q     <= '0;
      mid_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        follow_q <= cfg_wdata_i;
      end
      in_frame_q  <= in_frame_d;
      count_q     <= count_d;
      store_q     <= store_d;
      mid_valid_q <= mid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mid_q <= mid_d;
  end

  assign frame_valid_o = mid_valid_q;
  assign frame_o       = mid_q;

endmodule

// File: rtl/adfp_result.sv
// Area multiply and the result register that also holds the retained values.
module adfp_result (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                frame_valid_i,
  input  adfp_pkg::frame_t    frame_i,
  output logic                res_ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  pos_x_o,
  output logic signed [15:0]  pos_y_o,
  output logic signed [15:0]  box_width_o,
  output logic signed [15:0]  box_height_o,
  output logic signed [31:0]  box_area_o
);

  logic        valid_q, valid_d;
  logic [15:0] x_q, x_d, y_q, y_d, w_q, w_d, h_q, h_d;
  logic [31:0] area_q, area_d;
  logic        out_ready;
  logic        load;
  logic signed [31:0] product;

  assign out_ready   = !valid_q || !out_stall_i;
  assign res_ready_o = out_ready;
  assign load        = frame_valid_i && out_ready;
  assign product     = signed'(frame_i.w) * signed'(frame_i.h);

  always_comb begin
    valid_d = out_ready ? frame_valid_i : valid_q;
    x_d     = x_q;
    y_d     = y_q;
    w_d     = w_q;
    h_d     = h_q;
    area_d  = area_q;
    if (load) begin
      x_d = frame_i.x;
      y_d = frame_i.y;
      if (frame_i.follow) begin
        w_d    = frame_i.w;
        h_d    = frame_i.h;
        area_d = product;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      x_q     <= adfp_pkg::ResetX;
      y_q     <= adfp_pkg::ResetY;
      w_q     <= '0;
      h_q     <= '0;
      area_q  <= '0;
    end else begin
      valid_q <= valid_d;
      x_q     <= x_d;
      y_q     <= y_d;
      w_q     <= w_d;
      h_q     <= h_d;
      area_q  <= area_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign pos_x_o      = signed'(x_q);
  assign pos_y_o      = signed'(y_q);
  assign box_width_o  = signed'(w_q);
  assign box_height_o = signed'(h_q);
  assign box_area_o   = signed'(area_q);

endmodule

// File: rtl/ascii_decimal_frame_parser.sv
// Top level of the ASCII decimal frame parser.
// One byte is taken every cycle while the output side is not stalled.
// A closing byte gives its result through the decoded-frame register first, then
// through the area multiply and result register.
// Reset is asynchronous and active low; it idles the parser, clears the payload store
// and sets the retained results to X 160, Y 120 and zero width, height and area.
module ascii_decimal_frame_parser #(
  parameter int unsigned MaxPayload = adfp_pkg::MaxPayloadDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] box_width_o,
  output logic signed [15:0] box_height_o,
  output logic signed [31:0] box_area_o
);

  logic             frame_valid;
  adfp_pkg::frame_t frame;
  logic             res_ready;

  adfp_parser #(
    .MaxPayload(MaxPayload)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .res_ready_i  (res_ready),
    .frame_valid_o(frame_valid),
    .frame_o      (frame)
  );

  adfp_result u_result (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_valid_i(frame_valid),
    .frame_i      (frame),
    .res_ready_o  (res_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .box_width_o  (box_width_o),
    .box_height_o (box_height_o),
    .box_area_o   (box_area_o)
  );

endmodule
